>>> hw/rtl/tdpc_pkg.sv
// Shared types, constants and the control program of the trial-division prime collector.
package tdpc_pkg;

    // Number of slots in the prime store; the found count saturates here.
    localparam int CAPACITY = 4096;

    localparam int CAND_W = 31;
    localparam int SLOT_W = 12;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    // The largest divisor ever tried is just below the square root of 2^31.
    localparam int DIV_W  = 16;
    localparam int SQ_W   = 32;
    localparam int BIT_W  = $clog2(CAND_W);
    localparam int UPC_W  = 3;

    typedef logic [UPC_W-1:0] t_upc;

    // Step addresses of the control program.
    localparam t_upc S_IDLE  = 3'd0;
    localparam t_upc S_SMALL = 3'd1;
    localparam t_upc S_TEST  = 3'd2;
    localparam t_upc S_DIV   = 3'd3;
    localparam t_upc S_REM   = 3'd4;
    localparam t_upc S_PRIME = 3'd5;
    localparam t_upc S_COMP  = 3'd6;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_INIT_D,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_NEXT_D,
        OP_WR_PRIME,
        OP_WR_COMP
    } t_op;

    typedef enum logic [2:0] {
        C_NOT_VALID,
        C_OUT_BUSY,
        C_LT2,
        C_SQ_GT,
        C_BIT_MORE,
        C_REM_ZERO
    } t_cond;

    typedef struct packed {
        t_cond cond;
        logic  hold;
        t_upc  jump;
        t_upc  next;
        t_op   op;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic exec;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic lt2;
        logic sq_gt;
        logic bit_more;
        logic rem_zero;
    } t_status;

    // The control program: when the condition holds the step goes to jump, otherwise
    // to next. A step with hold set does not run its operation while it waits.
    function automatic t_uword ucode_rom(input t_upc addr);
        t_uword w;
        unique case (addr)
            S_IDLE:  w = '{C_NOT_VALID, 1'b1, S_IDLE,  S_SMALL, OP_LOAD};
            S_SMALL: w = '{C_LT2,       1'b0, S_COMP,  S_TEST,  OP_INIT_D};
            S_TEST:  w = '{C_SQ_GT,     1'b0, S_PRIME, S_DIV,   OP_DIV_INIT};
            S_DIV:   w = '{C_BIT_MORE,  1'b0, S_DIV,   S_REM,   OP_DIV_STEP};
            S_REM:   w = '{C_REM_ZERO,  1'b0, S_COMP,  S_TEST,  OP_NEXT_D};
            S_PRIME: w = '{C_OUT_BUSY,  1'b1, S_PRIME, S_IDLE,  OP_WR_PRIME};
            S_COMP:  w = '{C_OUT_BUSY,  1'b1, S_COMP,  S_IDLE,  OP_WR_COMP};
            default: w = '{C_OUT_BUSY,  1'b1, S_IDLE,  S_IDLE,  OP_WR_COMP};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/tdpc_if.sv
// Handshake channels of the prime collector: candidate items in, result items out.
interface tdpc_in_if
    import tdpc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CAND_W-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpc_out_if
    import tdpc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              is_prime_flag;
    logic              stored;
    logic [SLOT_W-1:0] slot;

    modport source (output valid, output is_prime_flag, output stored, output slot,
                    input ready);
    modport sink   (input valid, input is_prime_flag, input stored, input slot,
                    output ready);
endinterface

>>> hw/rtl/tdpc_sequencer.sv
// Step counter and control store of the prime collector.
module tdpc_sequencer
    import tdpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_word;
    logic   w_cond;

    always_comb begin
        w_word = ucode_rom(r_upc);
        unique case (w_word.cond)
            C_NOT_VALID: w_cond = !i_status.in_valid;
            C_OUT_BUSY:  w_cond = i_status.out_busy;
            C_LT2:       w_cond = i_status.lt2;
            C_SQ_GT:     w_cond = i_status.sq_gt;
            C_BIT_MORE:  w_cond = i_status.bit_more;
            C_REM_ZERO:  w_cond = i_status.rem_zero;
            default:     w_cond = 1'b0;
        endcase
        n_upc       = w_cond ? w_word.jump : w_word.next;
        o_ctrl.op   = w_word.op;
        o_ctrl.exec = !(w_cond && w_word.hold);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    a_upc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc <= S_COMP)
        else $error("step counter left the program");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.op == OP_LOAD && o_ctrl.exec) |=> r_upc == S_SMALL)
        else $error("loaded item did not start its test");

    a_wait_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == S_PRIME && i_status.out_busy) |=> r_upc == S_PRIME)
        else $error("prime result left while output was busy");

endmodule

>>> hw/rtl/tdpc_datapath.sv
// Candidate, divisor, square and remainder registers, found count and result register.
module tdpc_datapath
    import tdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    input  logic              i_in_valid,
    input  logic [CAND_W-1:0] i_candidate,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic              o_is_prime_flag,
    output logic              o_stored,
    output logic [SLOT_W-1:0] o_slot
);

    logic [CAND_W-1:0] r_n;
    logic [DIV_W-1:0]  r_d;
    logic [SQ_W-1:0]   r_sq;
    logic [DIV_W-1:0]  r_rem;
    logic [BIT_W-1:0]  r_bit;
    logic [CNT_W-1:0]  r_count;
    logic              r_out_valid;
    logic              r_flag;
    logic              r_stored;
    logic [SLOT_W-1:0] r_slot;

    logic [DIV_W:0]   w_rem_sh;
    logic [DIV_W+1:0] w_diff;
    logic [DIV_W-1:0] w_rem_next;
    logic             w_has_room;
    logic             w_run;

    always_comb begin
        w_rem_sh   = {r_rem, r_n[r_bit]};
        w_diff     = {1'b0, w_rem_sh} - {2'b00, r_d};
        w_rem_next = w_diff[DIV_W+1] ? w_rem_sh[DIV_W-1:0] : w_diff[DIV_W-1:0];
        w_has_room = r_count < CNT_W'(CAPACITY);
        w_run      = i_ctrl.exec;

        o_status.in_valid = i_in_valid;
        o_status.out_busy = r_out_valid && !i_out_ready;
        o_status.lt2      = r_n < CAND_W'(2);
        o_status.sq_gt    = r_sq > {1'b0, r_n};
        o_status.bit_more = r_bit != '0;
        o_status.rem_zero = r_rem == '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_run) begin
            unique case (i_ctrl.op)
                OP_LOAD: begin
                    r_n <= i_candidate;
                end
                OP_INIT_D: begin
                    r_d  <= DIV_W'(2);
                    r_sq <= SQ_W'(4);
                end
                OP_DIV_INIT: begin
                    r_rem <= '0;
                    r_bit <= BIT_W'(CAND_W - 1);
                end
                OP_DIV_STEP: begin
                    r_rem <= w_rem_next;
                    r_bit <= r_bit - BIT_W'(1);
                end
                OP_NEXT_D: begin
                    // (d+1)^2 = d^2 + 2d + 1
                    r_sq <= r_sq + SQ_W'({r_d, 1'b1});
                    r_d  <= r_d + DIV_W'(1);
                end
                OP_WR_PRIME: begin
                    r_flag   <= 1'b1;
                    r_stored <= w_has_room;
                    r_slot   <= w_has_room ? SLOT_W'(r_count) : '0;
                end
                OP_WR_COMP: begin
                    r_flag   <= 1'b0;
                    r_stored <= 1'b0;
                    r_slot   <= '0;
                end
                default: begin
                    r_flag <= r_flag;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_run && (i_ctrl.op == OP_WR_PRIME || i_ctrl.op == OP_WR_COMP)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_run && i_ctrl.op == OP_WR_PRIME && w_has_room) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_prime_flag = r_flag;
    assign o_stored        = r_stored;
    assign o_slot          = r_slot;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("found count passed capacity");

    a_stored_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_stored) |-> r_flag)
        else $error("stored result not flagged prime");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_stored) |-> r_slot == '0)
        else $error("slot not zero for unstored result");

endmodule

>>> hw/rtl/trial_division_prime_collector.sv
// Top level of the trial-division prime collector.
//
//  channel   | modport | payload                          | moves
//  ----------+---------+----------------------------------+-----------------------------
//  i_in      | sink    | candidate[30:0]                  | one candidate item
//  o_out     | source  | is_prime_flag, stored, slot[11:0]| one result item per candidate
//
// A candidate below 2 goes from the load step through the small check to the composite
// write step, which fills the output register; the program then returns to the load step
// for the next candidate. Otherwise each tried divisor takes the bound check, 31 steps of
// the one-bit restoring remainder unit and the remainder check, so the time for an item
// grows with the divisors tried; most of it is spent in the remainder unit.
// Reset: synchronous, active low; it clears the step counter, the found count and the
// output valid flag, and input ready stays low while it is asserted. Stalls: a finished
// result waits in the output register while the next candidate is accepted; only when a
// second result is ready and the first is still untaken does the program hold at its
// write step.
module trial_division_prime_collector
    import tdpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tdpc_in_if.sink           i_in,
    tdpc_out_if.source        o_out
);

    // The sequencer steps through the control program; each step's control word tells
    // the datapath which operation to run and whether to run it this cycle.
    t_ctrl   w_ctrl;
    t_status w_status;

    tdpc_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    tdpc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_in_valid      (i_in.valid),
        .i_candidate     (i_in.candidate),
        .i_out_ready     (o_out.ready),
        .o_status        (w_status),
        .o_out_valid     (o_out.valid),
        .o_is_prime_flag (o_out.is_prime_flag),
        .o_stored        (o_out.stored),
        .o_slot          (o_out.slot)
    );

    // A candidate item is taken only at the load step of the program, and never while
    // reset is asserted.
    assign i_in.ready = i_rst_n && (w_ctrl.op == OP_LOAD);

endmodule
